FILE: src/hvd_pkg.sv
`timescale 1ns / 1ps
// shared constants, tables and helpers for the haversine distance core
package hvd_pkg;

  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;
  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned R100_W   = 30;
  localparam int unsigned ROT_XY_W = 34;
  localparam int unsigned ROT_Z_W  = 33;
  localparam int unsigned TRIG_W   = 32;
  localparam int unsigned SQ_IN_W  = 61;
  localparam int unsigned SQ_RES_W = 62;
  localparam int unsigned SQ_OUT_W = 31;
  localparam int unsigned SQ_STEPS = 31;

  localparam logic signed [ROT_XY_W-1:0] GAIN_Q30 = 34'sd652032875;
  localparam logic signed [ROT_XY_W-1:0] ONE_Q30  = 34'sd1073741824;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  function automatic logic signed [TRIG_W-1:0] clamp_q30(
    input logic signed [ROT_XY_W-1:0] v
  );
    logic signed [ROT_XY_W-1:0] r;
    r = v;
    if (v > ONE_Q30) r = ONE_Q30;
    if (v < -ONE_Q30) r = -ONE_Q30;
    return r[TRIG_W-1:0];
  endfunction

endpackage

FILE: src/hvd_sincos.sv
`timescale 1ns / 1ps
// pipelined rotation cordic giving sine and cosine of a binary angle
module hvd_sincos #(
  parameter int unsigned N = hvd_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                              clk_i,
  input  logic signed [hvd_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [hvd_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [hvd_pkg::TRIG_W-1:0]  cos_o
);
  import hvd_pkg::*;

  logic signed [ROT_XY_W-1:0] x_w [N+1];
  logic signed [ROT_XY_W-1:0] y_w [N+1];
  logic signed [ROT_Z_W-1:0]  z_w [N+1];
  logic signed [ROT_XY_W-1:0] x_q [N];
  logic signed [ROT_XY_W-1:0] y_q [N];
  logic signed [ROT_Z_W-1:0]  z_q [N];
  logic                       neg_p_q [N+1];
  logic                       zero_p_q [N+1];

  logic signed [ROT_Z_W-1:0] z0_d, z0_q;
  logic                      neg_d;
  logic [ANGLE_W-1:0]        u_fold;

  // fold into the right half plane
  always_comb begin
    neg_d  = (angle_i > 32'sd1073741824) || (angle_i < -32'sd1073741824);
    u_fold = neg_d ? (angle_i ^ 32'h8000_0000) : angle_i;
    z0_d   = ROT_Z_W'($signed(u_fold));
  end

  always_ff @(posedge clk_i) begin
    z0_q        <= z0_d;
    neg_p_q[0]  <= neg_d;
    zero_p_q[0] <= (angle_i == '0);
  end

  assign x_w[0] = GAIN_Q30;
  assign y_w[0] = '0;
  assign z_w[0] = z0_q;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [ROT_XY_W-1:0] dx, dy;
    logic signed [ROT_Z_W-1:0]  at;
    assign dx = y_w[i] >>> i;
    assign dy = x_w[i] >>> i;
    assign at = $signed({1'b0, ATAN_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (!z_w[i][ROT_Z_W-1]) begin
        x_q[i] <= x_w[i] - dx;
        y_q[i] <= y_w[i] + dy;
        z_q[i] <= z_w[i] - at;
      end else begin
        x_q[i] <= x_w[i] + dx;
        y_q[i] <= y_w[i] - dy;
        z_q[i] <= z_w[i] + at;
      end
      neg_p_q[i+1]  <= neg_p_q[i];
      zero_p_q[i+1] <= zero_p_q[i];
    end
    assign x_w[i+1] = x_q[i];
    assign y_w[i+1] = y_q[i];
    assign z_w[i+1] = z_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (zero_p_q[N]) begin
      sin_o <= '0;
      cos_o <= TRIG_W'(ONE_Q30);
    end else if (neg_p_q[N]) begin
      sin_o <= clamp_q30(-y_w[N]);
      cos_o <= clamp_q30(-x_w[N]);
    end else begin
      sin_o <= clamp_q30(y_w[N]);
      cos_o <= clamp_q30(x_w[N]);
    end
  end

endmodule

FILE: src/hvd_isqrt.sv
`timescale 1ns / 1ps
// pipelined floor square root, one result bit per stage
module hvd_isqrt (
  input  logic                          clk_i,
  input  logic [hvd_pkg::SQ_IN_W-1:0]   v_i,
  output logic [hvd_pkg::SQ_OUT_W-1:0]  root_o
);
  import hvd_pkg::*;

  logic [SQ_IN_W-1:0]  v_w   [SQ_STEPS+1];
  logic [SQ_RES_W-1:0] res_w [SQ_STEPS+1];
  logic [SQ_IN_W-1:0]  v_q   [SQ_STEPS];
  logic [SQ_RES_W-1:0] res_q [SQ_STEPS];

  assign v_w[0]   = v_i;
  assign res_w[0] = '0;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    localparam int unsigned K = SQ_STEPS - 1 - j;
    logic [SQ_RES_W-1:0] bitv, trial;
    assign bitv  = SQ_RES_W'(1) << (2 * K);
    assign trial = res_w[j] + bitv;
    always_ff @(posedge clk_i) begin
      if (SQ_RES_W'(v_w[j]) >= trial) begin
        v_q[j]   <= v_w[j] - trial[SQ_IN_W-1:0];
        res_q[j] <= (res_w[j] >> 1) + bitv;
      end else begin
        v_q[j]   <= v_w[j];
        res_q[j] <= res_w[j] >> 1;
      end
    end
    assign v_w[j+1]   = v_q[j];
    assign res_w[j+1] = res_q[j];
  end

  assign root_o = res_w[SQ_STEPS][SQ_OUT_W-1:0];

endmodule

FILE: src/haversine_distance_core.sv
`timescale 1ns / 1ps
// top level of the pipelined haversine great-circle distance core
//
// usage: drive the four binary angles (2^32 units per turn) and raise start.
// busy stays low, so a request is taken at every edge where start is high,
// one pair per cycle with no gaps needed.
// each request produces one result: done_o is high for one cycle together
// with distance_cm_o (centimeters, truncated, saturated at 2^32-1).
// the pipeline holds two cordic chains of one step per stage, a 31-stage
// square root, and the multiplier stages for the haversine term and the
// radius scaling. results leave in request order and cannot be held off by
// the receiver. the user must write the radius register with cfg_we_i and
// cfg_wdata_i only while no request is in flight; the core does not check
// this. reset sets it to 6371000 m and clears all in-flight requests.
module haversine_distance_core #(
  parameter int unsigned CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hvd_pkg::ANGLE_W-1:0]  first_latitude_i,
  input  logic signed [hvd_pkg::ANGLE_W-1:0]  first_longitude_i,
  input  logic signed [hvd_pkg::ANGLE_W-1:0]  second_latitude_i,
  input  logic signed [hvd_pkg::ANGLE_W-1:0]  second_longitude_i,
  input  logic                                cfg_we_i,
  input  logic [hvd_pkg::RADIUS_W-1:0]        cfg_wdata_i,
  output logic                                done_o,
  output logic [hvd_pkg::DIST_W-1:0]          distance_cm_o
);
  import hvd_pkg::*;

  localparam int unsigned N   = CORDIC_ITERATIONS;
  localparam int unsigned LAT = 2 * N + 41;
  localparam int unsigned VXY_W = 35;

  logic [LAT-1:0]    vld_q;
  logic [R100_W-1:0] r100_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      r100_q <= R100_W'(RADIUS_RESET) * R100_W'(100);
    end else begin
      vld_q <= {vld_q[LAT-2:0], start};
      if (cfg_we_i) r100_q <= R100_W'(cfg_wdata_i) * R100_W'(100);
    end
  end

  // half differences and latitudes into four rotators
  logic signed [ANGLE_W-1:0] dlat, dlon, hlat, hlon;
  assign dlat = second_latitude_i - first_latitude_i;
  assign dlon = second_longitude_i - first_longitude_i;
  assign hlat = dlat >>> 1;
  assign hlon = dlon >>> 1;

  logic signed [TRIG_W-1:0] s1, s2, c1, c2;

  hvd_sincos #(.N(N)) u_sc_dlat (.clk_i, .angle_i(hlat), .sin_o(s1), .cos_o());
  hvd_sincos #(.N(N)) u_sc_dlon (.clk_i, .angle_i(hlon), .sin_o(s2), .cos_o());
  hvd_sincos #(.N(N)) u_sc_lat1 (.clk_i, .angle_i(first_latitude_i), .sin_o(),
                                 .cos_o(c1));
  hvd_sincos #(.N(N)) u_sc_lat2 (.clk_i, .angle_i(second_latitude_i), .sin_o(),
                                 .cos_o(c2));

  // haversine term a in q60
  logic signed [63:0]  cc_full, t_full;
  logic signed [31:0]  cc_q, t_q;
  logic signed [62:0]  ss1_q, ss1_q2, sum_a;
  logic signed [TRIG_W-1:0] s2_q, s2_q2;
  logic signed [61:0]  t2;
  logic [SQ_IN_W-1:0]  a_q, sa_q, sb_q;

  assign cc_full = c1 * c2;
  assign t_full  = cc_q * s2_q;
  assign t2      = 62'(t_q) * 62'(s2_q2);
  assign sum_a   = ss1_q2 + 63'(t2);

  always_ff @(posedge clk_i) begin
    cc_q   <= 32'(cc_full >>> 30);
    ss1_q  <= 63'(s1 * s1);
    s2_q   <= s2;
    t_q    <= 32'(t_full >>> 30);
    ss1_q2 <= ss1_q;
    s2_q2  <= s2_q;
    if (sum_a < 0) a_q <= '0;
    else if (sum_a > 63'sd1152921504606846976) a_q <= SQ_IN_W'(1) << 60;
    else a_q <= sum_a[SQ_IN_W-1:0];
    sa_q <= a_q;
    sb_q <= (SQ_IN_W'(1) << 60) - a_q;
  end

  logic [SQ_OUT_W-1:0] root_a, root_b;
  hvd_isqrt u_sqrt_a (.clk_i, .v_i(sa_q), .root_o(root_a));
  hvd_isqrt u_sqrt_b (.clk_i, .v_i(sb_q), .root_o(root_b));

  // vectoring cordic for atan2
  logic signed [VXY_W-1:0] vx_w [N+1];
  logic signed [VXY_W-1:0] vy_w [N+1];
  logic signed [VXY_W-1:0] vz_w [N+1];
  logic signed [VXY_W-1:0] vx_q [N];
  logic signed [VXY_W-1:0] vy_q [N];
  logic signed [VXY_W-1:0] vz_q [N];

  assign vx_w[0] = $signed({4'b0, root_b});
  assign vy_w[0] = $signed({4'b0, root_a});
  assign vz_w[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_vec
    logic signed [VXY_W-1:0] dx, dy, at;
    assign dx = vy_w[i] >>> i;
    assign dy = vx_w[i] >>> i;
    assign at = $signed({3'b0, ATAN_TAB[i]});
    always_ff @(posedge clk_i) begin
      if (!vy_w[i][VXY_W-1]) begin
        vx_q[i] <= vx_w[i] + dx;
        vy_q[i] <= vy_w[i] - dy;
        vz_q[i] <= vz_w[i] + at;
      end else begin
        vx_q[i] <= vx_w[i] - dx;
        vy_q[i] <= vy_w[i] + dy;
        vz_q[i] <= vz_w[i] - at;
      end
    end
    assign vx_w[i+1] = vx_q[i];
    assign vy_w[i+1] = vy_q[i];
    assign vz_w[i+1] = vz_q[i];
  end

  // central angle and scaling
  logic [31:0] ang_q;
  logic [61:0] prod_q;
  logic [63:0] lo_k_q;
  logic [61:0] hi_k_q;
  logic [62:0] scaled;
  logic [33:0] dist_full;

  assign scaled    = 63'(hi_k_q) + 63'(lo_k_q[63:32]);
  assign dist_full = scaled[62:29];

  always_ff @(posedge clk_i) begin
    if (vz_w[N] < 0) ang_q <= '0;
    else if (vz_w[N] > VXY_W'(ONE_Q30)) ang_q <= 32'd1 << 31;
    else ang_q <= {vz_w[N][30:0], 1'b0};
    prod_q <= 62'(r100_q) * 62'(ang_q);
    lo_k_q <= 64'(prod_q[31:0]) * 64'(TWO_PI_Q29);
    hi_k_q <= 62'(prod_q[61:32]) * 62'(TWO_PI_Q29);
    distance_cm_o <= (dist_full[33:32] != 2'b0) ? '1 : dist_full[31:0];
  end

  assign done_o = vld_q[LAT-1];

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LAT done_o) else $error("missing result");
  a_nolat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##LAT !done_o) else $error("spurious result");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> r100_q == R100_W'($past(cfg_wdata_i)) * R100_W'(100))
    else $error("radius not stored");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the haversine distance core with a built-in distance predictor
module testbench;
  import hvd_pkg::*;

  typedef struct packed {
    logic [31:0] lat1;
    logic [31:0] lon1;
    logic [31:0] lat2;
    logic [31:0] lon2;
  } point_pair_t;

  localparam longint ONE = 64'sd1 << 30;
  localparam int unsigned STEPS = CORDIC_ITERATIONS_DEF;
  localparam int TIMEOUT_CYCLES = 400000;

  logic clk_i, rst_ni, start, busy, cfg_we_i, done_o;
  logic [31:0] first_latitude_i, first_longitude_i, second_latitude_i, second_longitude_i;
  logic [RADIUS_W-1:0] cfg_wdata_i;
  logic [DIST_W-1:0] distance_cm_o;

  point_pair_t pair_queue[$];
  logic [31:0] distance_queue[$];
  logic [RADIUS_W-1:0] radius_m;
  int gap_pct;
  int errors;
  int cycles;
  logic took;

  haversine_distance_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .first_latitude_i(first_latitude_i), .first_longitude_i(first_longitude_i),
    .second_latitude_i(second_latitude_i), .second_longitude_i(second_longitude_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .distance_cm_o(distance_cm_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_one(input longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic void rotate(input logic [31:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    logic [31:0] u;
    bit neg;
    u = ang;
    if (u == 32'd0) begin
      s = 0;
      c = ONE;
      return;
    end
    z = longint'(signed'(u));
    neg = 1'b0;
    if (z > ONE || z < -ONE) begin
      u = u ^ 32'h8000_0000;
      z = longint'(signed'(u));
      neg = 1'b1;
    end
    x = 652032875;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    s = clamp_one(y);
    c = clamp_one(x);
  endfunction

  function automatic logic [31:0] half_delta(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return 32'(longint'(signed'(d)) >>> 1);
  endfunction

  function automatic longint root60(input longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint central_half(input longint y, input longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > ONE) z = ONE;
    return z;
  endfunction

  function automatic logic [31:0] predict_distance(input point_pair_t p, input logic [22:0] r);
    longint s1, s2, c1, c2, tmp, cc, hav, ang;
    longint unsigned prod, lo, hi, dist_cm;
    rotate(half_delta(p.lat1, p.lat2), s1, tmp);
    rotate(half_delta(p.lon1, p.lon2), s2, tmp);
    rotate(p.lat1, tmp, c1);
    rotate(p.lat2, tmp, c2);
    cc = (c1 * c2) >>> 30;
    hav = s1 * s1 + ((cc * s2) >>> 30) * s2;
    if (hav < 0) hav = 0;
    if (hav > (64'sd1 << 60)) hav = 64'sd1 << 60;
    ang = 2 * central_half(root60(hav), root60((64'd1 << 60) - hav));
    prod = longint'(r) * 100 * ang;
    lo = (prod & 64'hFFFF_FFFF) * longint'(TWO_PI_Q29);
    hi = (prod >> 32) * longint'(TWO_PI_Q29);
    dist_cm = (hi + (lo >> 32)) >> 29;
    if (dist_cm > 64'hFFFF_FFFF) dist_cm = 64'hFFFF_FFFF;
    return dist_cm[31:0];
  endfunction

  function automatic logic [31:0] rand_lat();
    return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
  endfunction

  function automatic point_pair_t rand_pair();
    point_pair_t p;
    int mode;
    mode = $urandom_range(9, 0);
    p.lat1 = rand_lat();
    p.lon1 = $urandom;
    p.lat2 = rand_lat();
    p.lon2 = $urandom;
    case (mode)
      0: begin
        p.lat2 = p.lat1;
        p.lon2 = p.lon1;
      end
      1: begin
        p.lat2 = p.lat1 + $urandom_range(4000, 0) - 2000;
        p.lon2 = p.lon1 + $urandom_range(4000, 0) - 2000;
      end
      2: begin
        p.lat1 = $urandom;
        p.lat2 = $urandom;
      end
      3: begin
        p.lat2 = -p.lat1;
        p.lon2 = p.lon1 + 32'h8000_0000 + $urandom_range(64, 0) - 32;
      end
      default: ;
    endcase
    return p;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (pair_queue.size() > 0 && $urandom_range(99, 0) >= gap_pct) begin
        point_pair_t p;
        p = pair_queue.pop_front();
        first_latitude_i <= p.lat1;
        first_longitude_i <= p.lon1;
        second_latitude_i <= p.lat2;
        second_longitude_i <= p.lon2;
        start <= 1'b1;
      end else start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
    if (rst_ni) begin
      took <= start && !busy;
      if (cfg_we_i) radius_m = cfg_wdata_i;
      if (start && !busy)
        distance_queue.push_back(predict_distance({first_latitude_i, first_longitude_i,
            second_latitude_i, second_longitude_i}, radius_m));
      if (done_o) begin
        if (distance_queue.size() == 0) begin
          errors++;
          $display("%t unexpected result: expected none, actual %0d", $time, distance_cm_o);
        end else begin
          logic [31:0] want;
          want = distance_queue.pop_front();
          if (distance_cm_o !== want) begin
            errors++;
            $display("%t distance_cm mismatch: expected %0d, actual %0d",
                     $time, want, distance_cm_o);
          end
        end
      end
    end
  end

  task automatic drain();
    wait (pair_queue.size() == 0 && !start && distance_queue.size() == 0);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] r);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random(input int n);
    for (int i = 0; i < n; i++) pair_queue.push_back(rand_pair());
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    first_latitude_i = '0;
    first_longitude_i = '0;
    second_latitude_i = '0;
    second_longitude_i = '0;
    took = 1'b0;
    errors = 0;
    cycles = 0;
    gap_pct = 11;
    radius_m = RADIUS_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed extremes, poles, antipodes, out-of-range latitudes
    pair_queue.push_back({32'h0, 32'h0, 32'h0, 32'h0});
    pair_queue.push_back({32'h1234_5678, 32'h9abc_def0, 32'h1234_5678, 32'h9abc_def0});
    pair_queue.push_back({32'h4000_0000, 32'h0, 32'hc000_0000, 32'h0});
    pair_queue.push_back({32'h4000_0000, 32'h8000_0000, 32'h4000_0000, 32'h7fff_ffff});
    pair_queue.push_back({32'hc000_0000, 32'h7fff_ffff, 32'h4000_0000, 32'h8000_0000});
    pair_queue.push_back({32'h0, 32'h0, 32'h0, 32'h8000_0000});
    pair_queue.push_back({32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff});
    pair_queue.push_back({32'h0, 32'h0, 32'h0, 32'h1});
    pair_queue.push_back({32'h1, 32'h0, 32'h0, 32'h0});
    pair_queue.push_back({32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0});
    pair_queue.push_back({32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0});
    pair_queue.push_back({32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h0});
    pair_queue.push_back({32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7fff_ffff});
    pair_queue.push_back({32'h2000_0000, 32'h1000_0000, 32'he000_0000, 32'h9000_0000});
    pair_queue.push_back({32'h3fff_ffff, 32'h0, 32'hc000_0001, 32'h8000_0000});
    pair_queue.push_back({32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555});
    drain();

    write_radius(23'h7f_ffff);
    load_random(280);
    drain();

    gap_pct = 50;
    write_radius(23'd1);
    load_random(280);
    drain();

    gap_pct = 0;
    write_radius(23'd0);
    load_random(20);
    drain();

    write_radius(23'($urandom_range(23'h7f_ffff, 1)));
    load_random(300);
    drain();

    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

FILE: haversine_distance_core.f
src/hvd_pkg.sv
src/hvd_sincos.sv
src/hvd_isqrt.sv
src/haversine_distance_core.sv
tb/sv/testbench.sv
